// File: src/multi_port_motor_watchdog_macros.svh
// Assertion macros shared by the watchdog checker.
`ifndef MULTI_PORT_MOTOR_WATCHDOG_MACROS_SVH
`define MULTI_PORT_MOTOR_WATCHDOG_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MPMW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define MPMW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mpmw_pkg.sv
// Types and constants of the multi-port watchdog.
`default_nettype none
package mpmw_pkg;

   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;
   localparam int OP_W      = 3;
   localparam int PORT_W    = 3;
   // wide enough to compare a port number against any cell number
   localparam int SEL_W     = 7;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 3'd0,
      OP_ADD        = 3'd1,
      OP_REMOVE     = 3'd2,
      OP_FEED       = 3'd3,
      OP_PAUSE      = 3'd4,
      OP_RESUME     = 3'd5,
      OP_MASTER_ON  = 3'd6,
      OP_MASTER_OFF = 3'd7
   } op_type;

   typedef enum logic [0:0] {
      REG_STARVE_TIMEOUT = 1'b0,
      REG_NONE           = 1'b1
   } reg_type;

   // broadcast from the control to every cell, qualified by the accept
   typedef struct packed {
      logic                 tick;
      logic                 add;
      logic                 remove;
      logic                 feed;
      logic                 stamp_all;
      logic                 check;
      logic [TIME_W-1:0]    time_now;
      logic [TIME_W-1:0]    time_next;
      logic [TIMEOUT_W-1:0] timeout;
   } ctrl_type;

   // handed from cell to cell: lowest starved port so far
   typedef struct packed {
      logic              found;
      logic [PORT_W-1:0] port;
   } link_type;

endpackage
`default_nettype wire

// File: src/mpmw_if.sv
// Request and response channel interfaces of the watchdog.
`default_nettype none
interface mpmw_req_if;
   logic                           valid;
   logic                           ready;
   logic [mpmw_pkg::OP_W-1:0]      op;
   logic [mpmw_pkg::PORT_W-1:0]    port_index;

   modport source (output valid, output op, output port_index, input ready);
   modport sink   (input valid, input op, input port_index, output ready);
endinterface

interface mpmw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           starved;
   logic [mpmw_pkg::PORT_W-1:0]    starved_port;
   logic                           master_on;
   logic                           paused_now;

   modport source (output valid, output starved, output starved_port,
                   output master_on, output paused_now, input ready);
   modport sink   (input valid, input starved, input starved_port,
                   input master_on, input paused_now, output ready);
endinterface
`default_nettype wire

// File: src/multi_port_motor_watchdog.sv
// Multi-port watchdog: control, time count, row of port cells and result register.
// An accepted request word updates the cells and latches starve flags; then, while
// busy, the priority search runs along the cell row and its result is registered
// in the result word. No new word is taken while busy or while a result word stalls.
// Reset (synchronous): clears time, port enables, master and pause, loads the
// timeout with 100; feed stamps are not cleared and need no clearing pass.
`default_nettype none
module multi_port_motor_watchdog #(
   parameter int NUM_PORTS = 8
) (
   input  wire                               clock,
   input  wire                               reset,
   mpmw_req_if.sink                          req,
   mpmw_rsp_if.source                        rsp,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [mpmw_pkg::ADDR_W-1:0]       paddr,
   input  wire  [mpmw_pkg::DATA_W-1:0]       pwdata,
   output logic [mpmw_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam int PortW = mpmw_pkg::PORT_W;
   localparam int SelW  = mpmw_pkg::SEL_W;

   logic [mpmw_pkg::TIME_W-1:0]    time_ff;
   logic [mpmw_pkg::TIME_W-1:0]    time_in;
   logic [mpmw_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [mpmw_pkg::TIMEOUT_W-1:0] timeout_in;
   logic                           master_ff;
   logic                           master_in;
   logic                           pause_ff;
   logic                           pause_in;
   logic                           busy_ff;
   logic                           busy_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           starved_ff;
   logic                           starved_in;
   logic [PortW-1:0]               port_ff;
   logic [PortW-1:0]               port_in;
   logic                           master_out_ff;
   logic                           master_out_in;
   logic                           pause_out_ff;
   logic                           pause_out_in;

   logic                           accept;
   logic                           cfg_write;
   mpmw_pkg::reg_type              reg_sel;
   mpmw_pkg::op_type               op;
   mpmw_pkg::ctrl_type             ctrl;
   logic [NUM_PORTS-1:0]           sel;
   mpmw_pkg::link_type             chain [NUM_PORTS+1];

   assign accept    = req.valid && req.ready;
   assign op        = mpmw_pkg::op_type'(req.op);
   assign reg_sel   = mpmw_pkg::reg_type'(paddr[2]);
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign req.ready = !busy_ff && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      case (reg_sel)
         mpmw_pkg::REG_STARVE_TIMEOUT:
            prdata = {{(mpmw_pkg::DATA_W-mpmw_pkg::TIMEOUT_W){1'b0}}, timeout_ff};
         default: prdata = '0;
      endcase
   end

   always_comb begin
      timeout_in = timeout_ff;
      if (cfg_write && reg_sel == mpmw_pkg::REG_STARVE_TIMEOUT) begin
         timeout_in = pwdata[mpmw_pkg::TIMEOUT_W-1:0];
      end
   end

   // decode the op into the broadcast to the cells
   always_comb begin
      ctrl           = '0;
      ctrl.time_now  = time_ff;
      ctrl.time_next = time_ff + 1'b1;
      ctrl.timeout   = timeout_ff;
      time_in        = time_ff;
      master_in      = master_ff;
      pause_in       = pause_ff;
      if (accept) begin
         case (op)
            mpmw_pkg::OP_TICK: begin
               ctrl.tick  = 1'b1;
               ctrl.check = master_ff && !pause_ff;
               time_in    = ctrl.time_next;
            end
            mpmw_pkg::OP_ADD:    ctrl.add    = 1'b1;
            mpmw_pkg::OP_REMOVE: ctrl.remove = 1'b1;
            mpmw_pkg::OP_FEED:   ctrl.feed   = 1'b1;
            mpmw_pkg::OP_PAUSE:  pause_in    = 1'b1;
            mpmw_pkg::OP_RESUME: begin
               ctrl.stamp_all = 1'b1;
               pause_in       = 1'b0;
            end
            mpmw_pkg::OP_MASTER_ON: begin
               if (!master_ff) begin
                  ctrl.stamp_all = 1'b1;
                  master_in      = 1'b1;
                  pause_in       = 1'b0;
               end
            end
            default: master_in = 1'b0;
         endcase
      end
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < NUM_PORTS; i++) begin : g_cell
      assign sel[i] = (SelW'(req.port_index) == SelW'(i));

      mpmw_cell #(
         .CELL_ID (PortW'(i))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .sel      (sel[i]),
         .ctrl     (ctrl),
         .link_in  (chain[i]),
         .link_out (chain[i+1])
      );
   end

   always_comb begin
      busy_in       = accept;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      starved_in    = starved_ff;
      port_in       = port_ff;
      master_out_in = master_out_ff;
      pause_out_in  = pause_out_ff;
      // load the result word in the cycle after the accept
      if (busy_ff) begin
         rsp_valid_in  = 1'b1;
         starved_in    = chain[NUM_PORTS].found;
         port_in       = chain[NUM_PORTS].port;
         master_out_in = master_ff;
         pause_out_in  = pause_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         timeout_ff   <= mpmw_pkg::TIMEOUT_RESET;
         master_ff    <= 1'b0;
         pause_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         timeout_ff   <= timeout_in;
         master_ff    <= master_in;
         pause_ff     <= pause_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      starved_ff    <= starved_in;
      port_ff       <= port_in;
      master_out_ff <= master_out_in;
      pause_out_ff  <= pause_out_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.starved      = starved_ff;
   assign rsp.starved_port = port_ff;
   assign rsp.master_on    = master_out_ff;
   assign rsp.paused_now   = pause_out_ff;

endmodule
`default_nettype wire

// File: src/mpmw_cell.sv
// One watchdog port: enable, feed stamp, starve flag and its link in the search chain.
`default_nettype none
module mpmw_cell #(
   parameter logic [2:0] CELL_ID = 3'd0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         sel,
   input  wire  mpmw_pkg::ctrl_type    ctrl,
   input  wire  mpmw_pkg::link_type    link_in,
   output mpmw_pkg::link_type          link_out
);

   logic                             en_ff;
   logic                             en_in;
   logic                             hit_ff;
   logic                             hit_in;
   logic [mpmw_pkg::TIME_W-1:0]      stamp_ff;
   logic [mpmw_pkg::TIME_W-1:0]      stamp_in;
   logic [mpmw_pkg::TIME_W-1:0]      elapsed;
   logic                             late;

   assign elapsed = ctrl.time_next - stamp_ff;
   assign late    = elapsed > {{(mpmw_pkg::TIME_W-mpmw_pkg::TIMEOUT_W){1'b0}}, ctrl.timeout};

   always_comb begin
      en_in    = en_ff;
      stamp_in = stamp_ff;
      if (ctrl.add && sel) begin
         en_in = 1'b1;
      end else if (ctrl.remove && sel) begin
         en_in = 1'b0;
      end
      // add stamps the port it just enabled
      if ((ctrl.add && sel) || (en_ff && ((ctrl.feed && sel) || ctrl.stamp_all))) begin
         stamp_in = ctrl.time_now;
      end
      // only an accepted, ungated tick can raise the flag; drop it otherwise
      hit_in = ctrl.tick && ctrl.check && en_ff && late;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         en_ff  <= en_in;
         hit_ff <= hit_in;
      end
      stamp_ff <= stamp_in;
   end

   // keep the lowest hit seen upstream
   always_comb begin
      link_out = link_in;
      if (!link_in.found && hit_ff) begin
         link_out.found = 1'b1;
         link_out.port  = CELL_ID;
      end
   end

endmodule
`default_nettype wire

// File: src/mpmw_checker.sv
// Port-level checks of the watchdog and their bind to the top level.
`default_nettype none
`include "multi_port_motor_watchdog_macros.svh"
module mpmw_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_starved,
   input wire [2:0] rsp_starved_port,
   input wire       rsp_master_on,
   input wire       rsp_paused_now
);

   `MPMW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_starved_port) && $stable(rsp_starved),
      "stalled response word changed")
   // the cycle after an accept searches the cell row; the word shows up after it
   `MPMW_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready,
      !rsp_valid ##1 rsp_valid,
      "no response word two cycles after accept")
   `MPMW_ASSERT_NOW(a_port_zero, rsp_valid && !rsp_starved,
      rsp_starved_port == 3'd0,
      "starved port set without starvation")
   `MPMW_ASSERT_NOW(a_starve_gate, rsp_valid && rsp_starved,
      rsp_master_on && !rsp_paused_now,
      "starvation reported while gated")

endmodule

bind multi_port_motor_watchdog mpmw_checker u_mpmw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_starved      (rsp.starved),
   .rsp_starved_port (rsp.starved_port),
   .rsp_master_on    (rsp.master_on),
   .rsp_paused_now   (rsp.paused_now)
);
`default_nettype wire
